// ===== src/ptss_pkg.sv =====
// Shared types and constants for the periodic task slot scheduler.
package ptss_pkg;

   // Most fire results that one process request may give.
   localparam int MaxResults = 8;
   localparam int KW = $clog2(MaxResults + 1);

   typedef enum logic [1:0] {
      ACT_START   = 2'd0,
      ACT_STOP    = 2'd1,
      ACT_PROCESS = 2'd2,
      ACT_UNKNOWN = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_PARAM     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_CATCH,
      S_REBASE,
      S_FIRE,
      S_CLAIM,
      S_REPLY,
      S_FLUSH
   } state_type;

   // One slot as held in the slot memory.
   typedef struct packed {
      logic [15:0] task_id;
      logic [31:0] period;
      logic [31:0] due;
   } slot_entry_type;

endpackage

// ===== src/periodic_task_slot_scheduler_top.sv =====
// Periodic task slot scheduler: slot pool, scan sequencer and result register.
// One item is in work at a time: a start or stop walks the slots, reading and comparing
// each active one; a process walks the slots and runs the catch-up steps for each due
// slot; a bad start or an unknown action goes straight to its reply. A stalled output
// holds the item until the result is taken.
// Synchronous reset clears the active bits, task_count, the sequencer and the output.
module periodic_task_slot_scheduler_top #(
   parameter int SLOT_COUNT    = 8,
   parameter int CATCHUP_LIMIT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // task_id[15:0], task_period[47:16], now_tick[79:48]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[1:0], fired_task_id[17:2], zero[23:18]
   output logic        rsp_tuser,   // fired[0]
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import ptss_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int N_W   = $clog2(CATCHUP_LIMIT + 1);

   state_type         state_ff, state_in;
   action_type        act_ff, act_in;
   logic [15:0]       id_ff, id_in;
   logic [31:0]       per_ff, per_in;
   logic [31:0]       now_ff, now_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [31:0]       due_ff, due_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [15:0]       fire_id_ff, fire_id_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [15:0]       pend_id_ff, pend_id_in;
   logic [KW-1:0]     k_ff, k_in;
   status_type        reply_ff, reply_in;
   logic [SLOT_COUNT-1:0] active_ff, active_in;
   logic [15:0]       task_count_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_fired_ff, rsp_fired_in;
   logic [15:0]       rsp_id_ff, rsp_id_in;
   logic              rsp_last_ff, rsp_last_in;

   slot_entry_type    rd_entry, wr_entry;
   logic [IDX_W-1:0]  wr_addr;
   logic              wr_en;

   logic [31:0]       add_a, add_sum, sub_b, lag;
   logic              reached;
   logic [N_W-1:0]    n_next;
   logic              out_free;
   logic              scan_done;
   logic              advance;
   logic              bad_start;
   action_type        req_act;

   // Slot contents: id, period and due tick of each slot.
   ptss_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (idx_ff),
      .rd_data (rd_entry)
   );

   // Shared period adder and wrap-safe reached test.
   assign add_a   = (state_ff == S_REBASE || state_ff == S_CLAIM) ? now_ff : due_ff;
   assign add_sum = add_a + per_ff;
   assign sub_b   = (state_ff == S_CHECK) ? rd_entry.due : add_sum;
   assign lag     = now_ff - sub_b;
   assign reached = ~lag[31];
   assign n_next  = n_ff + N_W'(1);

   assign out_free  = ~rsp_valid_ff | rsp_tready;
   assign scan_done = (idx_ff == IDX_W'(SLOT_COUNT - 1));
   assign req_act   = action_type'(req_tuser);
   assign bad_start = (req_tdata[15:0] >= task_count_ff) || (req_tdata[47:16] == 32'd0)
                      || req_tdata[47];

   // Slot memory writes: a claim on start, the new due tick after a fire.
   assign wr_en   = (state_ff == S_CLAIM) || (state_ff == S_FIRE);
   assign wr_addr = (state_ff == S_CLAIM) ? free_idx_ff : idx_ff;
   always_comb begin
      wr_entry.period = per_ff;
      if (state_ff == S_CLAIM) begin
         wr_entry.task_id = id_ff;
         wr_entry.due     = add_sum;
      end else begin
         wr_entry.task_id = fire_id_ff;
         wr_entry.due     = due_ff;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   // Sequencer: next state and all working registers.
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      id_in         = id_ff;
      per_in        = per_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      due_in        = due_ff;
      n_in          = n_ff;
      fire_id_in    = fire_id_ff;
      pend_vld_in   = pend_vld_ff;
      pend_id_in    = pend_id_ff;
      k_in          = k_ff;
      reply_in      = reply_ff;
      active_in     = active_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      advance       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in      = req_act;
               id_in       = req_tdata[15:0];
               per_in      = req_tdata[47:16];
               now_in      = req_tdata[79:48];
               idx_in      = '0;
               free_vld_in = 1'b0;
               pend_vld_in = 1'b0;
               k_in        = '0;
               case (req_act)
                  ACT_START: begin
                     if (bad_start) begin
                        reply_in = ST_PARAM;
                        state_in = S_REPLY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  ACT_STOP, ACT_PROCESS: state_in = S_SCAN;
                  default: begin
                     reply_in = ST_PARAM;
                     state_in = S_REPLY;
                  end
               endcase
            end
         end

         // Inactive slots are skipped; a start notes the first free one.
         S_SCAN: begin
            if (active_ff[idx_ff]) begin
               state_in = S_CHECK;
            end else begin
               if (act_ff == ACT_START && !free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = idx_ff;
               end
               advance = 1'b1;
            end
         end

         // Slot data has arrived from the memory.
         S_CHECK: begin
            case (act_ff)
               ACT_START: begin
                  if (rd_entry.task_id == id_ff) begin
                     reply_in = ST_OK;
                     state_in = S_REPLY;
                  end else begin
                     advance = 1'b1;
                  end
               end
               ACT_STOP: begin
                  if (rd_entry.task_id == id_ff) begin
                     active_in[idx_ff] = 1'b0;
                     reply_in          = ST_OK;
                     state_in          = S_REPLY;
                  end else begin
                     advance = 1'b1;
                  end
               end
               default: begin
                  if (reached) begin
                     due_in     = rd_entry.due;
                     per_in     = rd_entry.period;
                     fire_id_in = rd_entry.task_id;
                     n_in       = '0;
                     state_in   = S_CATCH;
                  end else begin
                     advance = 1'b1;
                  end
               end
            endcase
         end

         // One period step per cycle until caught up or at the limit.
         S_CATCH: begin
            if (reached && (n_next < N_W'(CATCHUP_LIMIT))) begin
               due_in = add_sum;
               n_in   = n_next;
            end else if (reached) begin
               state_in = S_REBASE;
            end else begin
               due_in   = add_sum;
               state_in = S_FIRE;
            end
         end

         // Still behind after the catch-up limit: due becomes now plus period.
         S_REBASE: begin
            due_in   = add_sum;
            state_in = S_FIRE;
         end

         // The previous fire goes out so that the newest can carry the last flag.
         S_FIRE: begin
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_fired_in  = 1'b1;
                  rsp_id_in     = pend_id_ff;
                  rsp_last_in   = 1'b0;
               end
               pend_vld_in = 1'b1;
               pend_id_in  = fire_id_ff;
               k_in        = k_ff + KW'(1);
               if (k_in == KW'(MaxResults)) begin
                  state_in = S_FLUSH;
               end else begin
                  advance = 1'b1;
               end
            end
         end

         S_CLAIM: begin
            active_in[free_idx_ff] = 1'b1;
            reply_in               = ST_OK;
            state_in               = S_REPLY;
         end

         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = reply_ff;
               rsp_fired_in  = 1'b0;
               rsp_id_in     = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_fired_in  = 1'b1;
               rsp_id_in     = pend_id_ff;
               rsp_last_in   = 1'b1;
               pend_vld_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Move to the next slot, or close the scan.
      if (advance) begin
         if (scan_done) begin
            case (act_ff)
               ACT_START: begin
                  if (free_vld_in) begin
                     state_in = S_CLAIM;
                  end else begin
                     reply_in = ST_FULL;
                     state_in = S_REPLY;
                  end
               end
               ACT_STOP: begin
                  reply_in = ST_NOT_FOUND;
                  state_in = S_REPLY;
               end
               default: state_in = S_FLUSH;
            endcase
         end else begin
            idx_in   = idx_ff + IDX_W'(1);
            state_in = S_SCAN;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= '0;
         task_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_vld_ff   <= 1'b0;
         free_vld_ff   <= 1'b0;
         k_ff          <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_vld_ff  <= pend_vld_in;
         free_vld_ff  <= free_vld_in;
         k_ff         <= k_in;
         if (csr_wr_en) begin
            task_count_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      id_ff         <= id_in;
      per_ff        <= per_in;
      now_ff        <= now_in;
      idx_ff        <= idx_in;
      free_idx_ff   <= free_idx_in;
      due_ff        <= due_in;
      n_ff          <= n_in;
      fire_id_ff    <= fire_id_in;
      pend_id_ff    <= pend_id_in;
      reply_ff      <= reply_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_id_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_fired_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // A fire result always reports success.
   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[1:0] == ST_OK)
      else $error("fire result with a failure status");

   // A status-only result is always the single result of its item.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("status result without last");

   // The fire count of one process request stays within the result limit.
   a_fire_count: assert property (@(posedge clock) disable iff (reset)
      k_ff <= KW'(MaxResults))
      else $error("too many fire results for one process request");

   // The catch-up loop never runs past its limit.
   a_catch_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CATCH |-> n_ff < N_W'(CATCHUP_LIMIT))
      else $error("catch-up count past its limit");
`endif

endmodule

// ===== src/ptss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
